// ===== design/ilp_pkg.sv =====
// Shared types and constants for the integer literal parser.
`default_nettype none
package ilp_pkg;

  localparam int CHAR_W      = 8;
  localparam int VALUE_W     = 63;
  localparam int DIGIT_W     = 4;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } radix_t;

  // One decoded character on its way from the front end to the back end.
  typedef struct packed {
    logic               has_char;
    logic               last;
    logic               is_hex;   // 0-9, a-f or A-F
    logic [DIGIT_W-1:0] dval;     // raw digit value when is_hex
    logic               is_pfx;   // b/B, o/O or x/X
    radix_t             pfx;      // radix that prefix letter selects
  } ilp_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ilp_qstat_t;

endpackage
`default_nettype wire

// ===== design/ilp_front.sv =====
// Front end: decodes one ASCII character into digit and prefix classes.
`default_nettype none
module ilp_front
  import ilp_pkg::*;
(
  input  wire logic [CHAR_W-1:0] character,
  input  wire logic              has_char,
  input  wire logic              last,
  output ilp_item_t              item
);

  localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h66;
  localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LB = 8'h62;
  localparam logic [CHAR_W-1:0] CH_UB = 8'h42;
  localparam logic [CHAR_W-1:0] CH_LO = 8'h6f;
  localparam logic [CHAR_W-1:0] CH_UO = 8'h4f;
  localparam logic [CHAR_W-1:0] CH_LX = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX = 8'h58;
  localparam logic [DIGIT_W-1:0] TEN  = 4'd10;

  logic          is_dec;
  logic          is_lo;
  logic          is_up;
  logic [CHAR_W-1:0] diff;

  always_comb begin
    is_dec = (character >= CH_0)  && (character <= CH_9);
    is_lo  = (character >= CH_LA) && (character <= CH_LF);
    is_up  = (character >= CH_UA) && (character <= CH_UF);
    if (is_dec) begin
      diff = character - CH_0;
    end else if (is_lo) begin
      diff = character - CH_LA;
    end else begin
      diff = character - CH_UA;
    end

    item.has_char = has_char;
    item.last     = last;
    item.is_hex   = is_dec || is_lo || is_up;
    item.dval     = is_dec ? diff[DIGIT_W-1:0] : (diff[DIGIT_W-1:0] + TEN);
    item.is_pfx   = 1'b1;
    item.pfx      = RADIX_DEC;
    if ((character == CH_LB) || (character == CH_UB)) begin
      item.pfx = RADIX_BIN;
    end else if ((character == CH_LO) || (character == CH_UO)) begin
      item.pfx = RADIX_OCT;
    end else if ((character == CH_LX) || (character == CH_UX)) begin
      item.pfx = RADIX_HEX;
    end else begin
      item.is_pfx = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== design/ilp_queue.sv =====
// Small FIFO of decoded characters between front end and back end.
`default_nettype none
module ilp_queue
  import ilp_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  ilp_item_t  wr_item,
  input  wire logic  pop,
  output ilp_item_t  rd_item,
  output ilp_qstat_t stat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ilp_item_t         mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == CntW'(Depth));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_item    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/ilp_back.sv =====
// Back end: radix tracking, multiply-add accumulation and result register.
`default_nettype none
module ilp_back
  import ilp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  ilp_item_t               item,
  input  ilp_qstat_t              qstat,
  output logic                    pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [VALUE_W:0]        m_tdata,
  output logic                    m_tuser
);

  localparam int FullW = VALUE_W + 5;
  localparam logic [1:0] POS_SAT = 2'd2;

  logic [VALUE_W-1:0] acc;
  radix_t             radix;
  logic [1:0]         pos;
  logic               fwz;
  logic               have;
  logic               err;

  logic [VALUE_W-1:0] acc_next;
  radix_t             radix_next;
  logic [1:0]         pos_next;
  logic               fwz_next;
  logic               have_next;
  logic               err_next;

  logic [FullW-1:0]   acc_ext;
  logic [FullW-1:0]   prod;
  logic [FullW-1:0]   full;
  logic               dig_ok;
  logic               ok;

  assign pop = !qstat.empty && (!item.last || !m_tvalid || m_tready);
  assign ok  = have_next && !err_next;

  always_comb begin
    acc_ext = {{(FullW-VALUE_W){1'b0}}, acc};
    case (radix)
      RADIX_BIN: prod = acc_ext << 1;
      RADIX_OCT: prod = acc_ext << 3;
      RADIX_HEX: prod = acc_ext << 4;
      default:   prod = (acc_ext << 3) + (acc_ext << 1);
    endcase
    full = prod + {{(FullW-DIGIT_W){1'b0}}, item.dval};

    case (radix)
      RADIX_BIN: dig_ok = item.is_hex && (item.dval < 4'd2);
      RADIX_OCT: dig_ok = item.is_hex && (item.dval < 4'd8);
      RADIX_HEX: dig_ok = item.is_hex;
      default:   dig_ok = item.is_hex && (item.dval < 4'd10);
    endcase

    acc_next   = acc;
    radix_next = radix;
    pos_next   = pos;
    fwz_next   = fwz;
    have_next  = have;
    err_next   = err;
    if (item.has_char) begin
      if (pos != POS_SAT) begin
        pos_next = pos + 1'b1;
      end
      if (!err) begin
        if ((pos == 2'd1) && fwz && item.is_pfx) begin
          // second char after a leading zero picks the radix
          radix_next = item.pfx;
          acc_next   = '0;
          have_next  = 1'b0;
        end else if (!dig_ok) begin
          err_next = 1'b1;
        end else begin
          if ((pos == 2'd0) && (item.dval == '0)) begin
            fwz_next = 1'b1;
          end
          if (|full[FullW-1:VALUE_W]) begin
            err_next = 1'b1;
          end else begin
            acc_next  = full[VALUE_W-1:0];
            have_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      radix    <= RADIX_DEC;
      pos      <= '0;
      fwz      <= 1'b0;
      have     <= 1'b0;
      err      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop && item.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        if (item.last) begin
          acc      <= '0;
          radix    <= RADIX_DEC;
          pos      <= '0;
          fwz      <= 1'b0;
          have     <= 1'b0;
          err      <= 1'b0;
        end else begin
          acc   <= acc_next;
          radix <= radix_next;
          pos   <= pos_next;
          fwz   <= fwz_next;
          have  <= have_next;
          err   <= err_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last) begin
      m_tdata <= {1'b0, ok ? acc_next : {VALUE_W{1'b0}}};
      m_tuser <= ok;
    end
  end

endmodule
`default_nettype wire

// ===== design/integer_literal_parser_top.sv =====
// Top level of the integer literal parser: front end, queue and back end.
// Usage:
//   Slave stream takes one ASCII character per beat: s_tdata is the character,
//   s_tuser says a character is present (clear only to end an empty literal),
//   s_tlast marks the final beat of a literal.
//   Master stream gives one beat per literal, on its last input beat:
//   m_tdata[62:0] is the value (0 when invalid), m_tdata[63] is zero,
//   m_tuser is valid_res.
//   Prefixes 0b/0B, 0o/0O, 0x/0X select base 2, 8, 16; otherwise decimal.
//   A bad digit, a prefix with no digits, an empty literal or a value past
//   2^63-1 gives valid_res 0.
// Timing:
//   m_tvalid is registered and rises at the edge that pops the last beat,
//   after any beats queued ahead of it. Throughput is one beat per cycle
//   unless a stalled result holds a last beat; each beat costs one pass
//   through the back end's combinational shift-add multiply and 68-bit
//   overflow compare. s_tready is low only while the 4-entry queue is full.
// Reset: rst (synchronous, active high) empties the queue, drops m_tvalid
//   and returns the parser to decimal with an empty accumulator.
// Stall: while m_tready is low, the result holds; the back end keeps
//   draining characters of the next literal and stops only at its last beat,
//   after which the queue fills and s_tready falls.
`default_nettype none
module integer_literal_parser_top
  import ilp_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [CHAR_W-1:0] s_tdata,   // [7:0] character
  input  wire logic              s_tuser,   // [0] has_char
  input  wire logic              s_tlast,   // last
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [VALUE_W:0]       m_tdata,   // [62:0] value, [63] zero pad
  output logic                   m_tuser    // [0] valid_res
);

  ilp_item_t  dec_item;
  ilp_item_t  q_item;
  ilp_qstat_t q_stat;
  logic       pop;
  logic       push;

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

  ilp_front u_front (
    .character (s_tdata),
    .has_char  (s_tuser),
    .last      (s_tlast),
    .item      (dec_item)
  );

  ilp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (dec_item),
    .pop     (pop),
    .rd_item (q_item),
    .stat    (q_stat)
  );

  ilp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .item     (q_item),
    .qstat    (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  // An invalid result never carries a value.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[VALUE_W-1:0] == '0))
    else $error("invalid result with nonzero value");

  // Back end only pops a filled queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // A last beat is never popped over an untaken result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pop && q_item.last && m_tvalid |-> m_tready)
    else $error("result overwritten while stalled");

  // Reset leaves the queue empty and no result pending.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> q_stat.empty && !m_tvalid)
    else $error("state not cleared by reset");
`endif

endmodule
`default_nettype wire
